// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An antecedent in a cycle implies a consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// An antecedent in a cycle implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/dtl_pkg.sv -----
// Shared constants and types for the decision tree leaf lookup block.
// Depends on nothing; used by the interfaces, the top-level module and the testbench.
package dtl_pkg;

  localparam int NODE_COUNT_DEF    = 256;
  localparam int FEATURE_COUNT_DEF = 64;
  localparam int VALUE_BITS_DEF    = 32;

  localparam int OP_W     = 2;
  localparam int NODE_W   = 8;
  localparam int FEAT_W   = 6;
  localparam int IN_VAL_W = 32;
  localparam int STEPS_W  = 9;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_NODE = 2'd0,
    OP_FEAT = 2'd1,
    OP_WALK = 2'd2
  } op_t;

endpackage

// ----- design/dtl_in_if.sv -----
// Input channel carrying one command word of the leaf lookup block.
// Depends on dtl_pkg.
interface dtl_in_if;
  logic                                valid;
  logic                                ready;
  logic [dtl_pkg::OP_W-1:0]            op;
  logic [dtl_pkg::NODE_W-1:0]          node_index;
  logic [dtl_pkg::FEAT_W-1:0]          node_feature;
  logic signed [dtl_pkg::IN_VAL_W-1:0] node_threshold;
  logic [dtl_pkg::NODE_W-1:0]          node_yes;
  logic [dtl_pkg::NODE_W-1:0]          node_no;
  logic [dtl_pkg::NODE_W-1:0]          node_missing;
  logic                                node_is_leaf;
  logic [dtl_pkg::FEAT_W-1:0]          feature_index;
  logic signed [dtl_pkg::IN_VAL_W-1:0] feature_value;
  logic                                feature_missing;

  modport source (
    output valid, op, node_index, node_feature, node_threshold, node_yes, node_no,
           node_missing, node_is_leaf, feature_index, feature_value, feature_missing,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, node_feature, node_threshold, node_yes, node_no,
           node_missing, node_is_leaf, feature_index, feature_value, feature_missing,
    output ready
  );
endinterface

// ----- design/dtl_out_if.sv -----
// Output channel carrying one classification result word.
// Depends on dtl_pkg.
interface dtl_out_if;
  logic                       valid;
  logic                       ready;
  logic [dtl_pkg::NODE_W-1:0] leaf_id;
  logic                       walk_overrun;

  modport source (output valid, leaf_id, walk_overrun, input ready);
  modport sink (input valid, leaf_id, walk_overrun, output ready);
endinterface

// ----- design/dtl_cfg_if.sv -----
// Configuration write channel for the step limit register.
// Depends on dtl_pkg.
interface dtl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dtl_pkg::STEPS_W-1:0] max_walk_steps;

  modport source (output valid, max_walk_steps, input ready);
  modport sink (input valid, max_walk_steps, output ready);
endinterface

// ----- design/dtl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/decision_tree_leaf_lookup_top.sv -----
// Top level of the decision tree leaf lookup block with missing-value routing.
// Depends on dtl_pkg, dtl_in_if, dtl_out_if, dtl_cfg_if, dtl_ram and assert_macros.svh.
//
// Usage: words on the request channel either write one tree node (op 0), write
// one feature value of the current observation (op 1), or classify the stored
// observation (op 2). Node and feature writes give no result.
// A classification walks the tree from node 0 and returns one word on the result
// channel with the leaf id and an overrun flag. The cfg channel writes the step
// limit and is always ready; write it only while no walk is in flight.
// Each inner node visited passes through S_NODE, which takes the node word from the
// node RAM, and then S_FEAT, which reads the feature RAM and compares. A walk stops
// at a leaf, or with the overrun flag set when the step limit is met or a child
// index is out of range; its result then waits in S_DONE for the output register.
// The request channel is not ready while a walk runs. A finished result sits in
// an output register, so loads are taken while it waits; a further walk holds
// its own result in its final state until the receiver drains the register.
// Reset sets the step limit to 256 and empties the output register. The node
// and feature memories are not cleared and must be written before use.
`include "assert_macros.svh"

module decision_tree_leaf_lookup_top #(
  parameter int NODE_COUNT    = dtl_pkg::NODE_COUNT_DEF,
  parameter int FEATURE_COUNT = dtl_pkg::FEATURE_COUNT_DEF,
  parameter int VALUE_BITS    = dtl_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dtl_in_if.sink       request,
  dtl_out_if.source    result,
  dtl_cfg_if.sink      cfg
);

  localparam int NA_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FA_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int KIDS_W = 3 * dtl_pkg::NODE_W;
  localparam int NWORD_W = 1 + dtl_pkg::FEAT_W + VALUE_BITS + KIDS_W;
  localparam int FWORD_W = 1 + VALUE_BITS;
  localparam int SW = dtl_pkg::STEPS_W;
  localparam int NW = dtl_pkg::NODE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NODE,
    S_FEAT,
    S_DONE
  } state_t;

  state_t state;
  logic [SW-1:0] max_walk_steps;
  logic [SW-1:0] visits;
  logic signed [VALUE_BITS-1:0] cur_thr;
  logic [KIDS_W-1:0] cur_kids;
  logic cur_feat_oor;
  logic [NW-1:0] res_leaf;
  logic res_over;
  logic out_valid;
  logic [NW-1:0] out_leaf;
  logic out_over;

  logic accept;
  logic node_we;
  logic feat_we;
  logic [NWORD_W-1:0] node_wdata;
  logic [FWORD_W-1:0] feat_wdata;
  logic [NA_W-1:0] node_raddr;
  logic [FA_W-1:0] feat_raddr;
  logic [NWORD_W-1:0] node_q;
  logic [FWORD_W-1:0] feat_q;

  logic q_leaf;
  logic [dtl_pkg::FEAT_W-1:0] q_feat;
  logic signed [VALUE_BITS-1:0] f_val;
  logic f_missing;
  logic [NW-1:0] next_node;
  logic next_oor;
  logic [SW-1:0] limit;
  logic out_free;

  assign accept = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.leaf_id = out_leaf;
  assign result.walk_overrun = out_over;
  assign out_free = !out_valid || result.ready;

  assign node_wdata = {request.node_is_leaf, request.node_feature,
                       VALUE_BITS'(request.node_threshold),
                       request.node_missing, request.node_no, request.node_yes};
  assign feat_wdata = {request.feature_missing, VALUE_BITS'(request.feature_value)};

  assign q_leaf = node_q[NWORD_W-1];
  assign q_feat = node_q[NWORD_W-2 -: dtl_pkg::FEAT_W];
  assign f_val = feat_q[VALUE_BITS-1:0];
  assign f_missing = cur_feat_oor || feat_q[FWORD_W-1];
  assign limit = (max_walk_steps == '0) ? SW'(1) : max_walk_steps;

  always_comb begin
    node_we = 1'b0;
    feat_we = 1'b0;
    if (accept) begin
      unique case (request.op)
        dtl_pkg::OP_NODE: node_we = 32'(request.node_index) < 32'(NODE_COUNT);
        dtl_pkg::OP_FEAT: feat_we = 32'(request.feature_index) < 32'(FEATURE_COUNT);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (f_missing) begin
      next_node = cur_kids[3*NW-1 -: NW];
    end else if (f_val < cur_thr) begin
      next_node = cur_kids[NW-1:0];
    end else begin
      next_node = cur_kids[2*NW-1 -: NW];
    end
    next_oor = 32'(next_node) >= 32'(NODE_COUNT);
    node_raddr = (state == S_FEAT) ? NA_W'(next_node) : '0;
    feat_raddr = FA_W'(q_feat);
  end

  dtl_ram #(
    .WIDTH(NWORD_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (NA_W'(request.node_index)),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_q)
  );

  dtl_ram #(
    .WIDTH(FWORD_W),
    .DEPTH(FEATURE_COUNT)
  ) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (FA_W'(request.feature_index)),
    .wdata (feat_wdata),
    .raddr (feat_raddr),
    .rdata (feat_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_walk_steps <= dtl_pkg::STEPS_RESET;
      out_valid <= 1'b0;
      visits <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_walk_steps <= cfg.max_walk_steps;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          visits <= '0;
          if (accept && request.op == dtl_pkg::OP_WALK) begin
            state <= S_NODE;
          end
        end
        S_NODE: begin
          if (q_leaf) begin
            if (visits == '0) begin
              res_leaf <= '0;
            end
            res_over <= 1'b0;
            state <= S_DONE;
          end else begin
            visits <= visits + SW'(1);
            cur_thr <= node_q[KIDS_W +: VALUE_BITS];
            cur_kids <= node_q[KIDS_W-1:0];
            cur_feat_oor <= 32'(q_feat) >= 32'(FEATURE_COUNT);
            state <= S_FEAT;
          end
        end
        S_FEAT: begin
          if (visits == limit || next_oor) begin
            res_leaf <= next_node;
            res_over <= 1'b1;
            state <= S_DONE;
          end else begin
            res_leaf <= next_node;
            state <= S_NODE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_leaf <= res_leaf;
            out_over <= res_over;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_walk_starts, clk, rst, accept && request.op == dtl_pkg::OP_WALK,
    state == S_NODE)
  `ASSERT_SAME(a_visits_bounded, clk, rst, state != S_IDLE, visits <= limit)
  `ASSERT_SAME(a_feat_after_visit, clk, rst, state == S_FEAT, visits != '0)
  `ASSERT_SAME(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE))

endmodule

// ----- test/decision_tree_leaf_lookup_top_test.sv -----
// Testbench for decision_tree_leaf_lookup_top: drives node, feature and classify words,
// predicts every leaf lookup from its own copy of the tables and checks each result word.
// Depends on dtl_pkg, dtl_in_if, dtl_out_if, dtl_cfg_if and the block itself.
module decision_tree_leaf_lookup_top_test;

  localparam logic [dtl_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 8000;

  typedef struct {
    logic [dtl_pkg::OP_W-1:0]            op;
    logic [dtl_pkg::NODE_W-1:0]          node_index;
    logic [dtl_pkg::FEAT_W-1:0]          node_feature;
    logic signed [dtl_pkg::IN_VAL_W-1:0] node_threshold;
    logic [dtl_pkg::NODE_W-1:0]          node_yes;
    logic [dtl_pkg::NODE_W-1:0]          node_no;
    logic [dtl_pkg::NODE_W-1:0]          node_missing;
    logic                                node_is_leaf;
    logic [dtl_pkg::FEAT_W-1:0]          feature_index;
    logic signed [dtl_pkg::IN_VAL_W-1:0] feature_value;
    logic                                feature_missing;
  } tree_word_t;

  typedef struct {
    logic [dtl_pkg::NODE_W-1:0] leaf_id;
    logic                       walk_overrun;
  } leaf_result_t;

  logic clk;
  logic rst;

  dtl_in_if  request_ch ();
  dtl_out_if result_ch ();
  dtl_cfg_if cfg_ch ();

  decision_tree_leaf_lookup_top u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  logic [dtl_pkg::FEAT_W-1:0]          tree_feat [256];
  logic signed [dtl_pkg::IN_VAL_W-1:0] tree_thr [256];
  logic [dtl_pkg::NODE_W-1:0]          tree_yes [256];
  logic [dtl_pkg::NODE_W-1:0]          tree_no [256];
  logic [dtl_pkg::NODE_W-1:0]          tree_miss [256];
  logic                                tree_leaf [256];
  logic signed [dtl_pkg::IN_VAL_W-1:0] obs_value [64];
  logic                                obs_missing [64];
  logic [dtl_pkg::STEPS_W-1:0]         walk_limit;

  leaf_result_t expected_leaves [$];

  int  error_count = 0;
  int  walks_sent = 0;
  int  loads_sent = 0;
  int  results_checked = 0;
  int  overruns_seen = 0;
  int  hold_cycles = 0;
  int  idle_count = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic leaf_result_t predict_leaf();
    leaf_result_t               r;
    int                         limit;
    int                         visits;
    logic [dtl_pkg::NODE_W-1:0] node;
    limit = (walk_limit == 0) ? 1 : int'(walk_limit);
    node = '0;
    visits = 0;
    r.walk_overrun = 1'b1;
    while (visits < limit) begin
      if (tree_leaf[node]) begin
        r.walk_overrun = 1'b0;
        break;
      end
      visits++;
      if (obs_missing[tree_feat[node]])
        node = tree_miss[node];
      else if (obs_value[tree_feat[node]] < tree_thr[node])
        node = tree_yes[node];
      else
        node = tree_no[node];
    end
    r.leaf_id = node;
    return r;
  endfunction

  function automatic tree_word_t random_word();
    tree_word_t c;
    c.op = dtl_pkg::OP_W'($urandom);
    c.node_index = dtl_pkg::NODE_W'($urandom);
    c.node_feature = dtl_pkg::FEAT_W'($urandom);
    c.node_threshold = $urandom;
    c.node_yes = dtl_pkg::NODE_W'($urandom);
    c.node_no = dtl_pkg::NODE_W'($urandom);
    c.node_missing = dtl_pkg::NODE_W'($urandom);
    c.node_is_leaf = 1'($urandom);
    c.feature_index = dtl_pkg::FEAT_W'($urandom);
    c.feature_value = $urandom;
    c.feature_missing = 1'($urandom);
    return c;
  endfunction

  function automatic tree_word_t node_word(input logic [dtl_pkg::NODE_W-1:0] idx,
                                           input logic [dtl_pkg::FEAT_W-1:0] feat,
                                           input logic signed [dtl_pkg::IN_VAL_W-1:0] thr,
                                           input logic [dtl_pkg::NODE_W-1:0] yes,
                                           input logic [dtl_pkg::NODE_W-1:0] no,
                                           input logic [dtl_pkg::NODE_W-1:0] miss,
                                           input logic leaf);
    tree_word_t c;
    c = random_word();
    c.op = dtl_pkg::OP_NODE;
    c.node_index = idx;
    c.node_feature = feat;
    c.node_threshold = thr;
    c.node_yes = yes;
    c.node_no = no;
    c.node_missing = miss;
    c.node_is_leaf = leaf;
    return c;
  endfunction

  function automatic tree_word_t feat_word(input logic [dtl_pkg::FEAT_W-1:0] idx,
                                           input logic signed [dtl_pkg::IN_VAL_W-1:0] value,
                                           input logic miss);
    tree_word_t c;
    c = random_word();
    c.op = dtl_pkg::OP_FEAT;
    c.feature_index = idx;
    c.feature_value = value;
    c.feature_missing = miss;
    return c;
  endfunction

  function automatic tree_word_t walk_word();
    tree_word_t c;
    c = random_word();
    c.op = dtl_pkg::OP_WALK;
    return c;
  endfunction

  function automatic logic signed [dtl_pkg::IN_VAL_W-1:0] pick_value();
    logic signed [dtl_pkg::IN_VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = tree_thr[$urandom_range(0, 255)];
      3: v = $signed($urandom_range(0, 512)) - 256;
      default: v = $urandom;
    endcase
    if ($isunknown(v)) v = $urandom;
    return v;
  endfunction

  // Children point to higher indices, so a well-formed tree always ends in a leaf.
  function automatic tree_word_t grown_node(input int idx, input bit noisy);
    int hop_yes;
    int hop_no;
    int hop_miss;
    hop_yes = idx + $urandom_range(1, 32);
    hop_no = idx + $urandom_range(1, 32);
    hop_miss = idx + $urandom_range(1, 32);
    if (hop_yes > 255) hop_yes = 255;
    if (hop_no > 255) hop_no = 255;
    if (hop_miss > 255) hop_miss = 255;
    if (noisy)
      return node_word(dtl_pkg::NODE_W'(idx), dtl_pkg::FEAT_W'($urandom), pick_value(),
                       dtl_pkg::NODE_W'($urandom), dtl_pkg::NODE_W'($urandom),
                       dtl_pkg::NODE_W'($urandom), $urandom_range(0, 3) == 0);
    return node_word(dtl_pkg::NODE_W'(idx), dtl_pkg::FEAT_W'($urandom), pick_value(),
                     dtl_pkg::NODE_W'(hop_yes), dtl_pkg::NODE_W'(hop_no),
                     dtl_pkg::NODE_W'(hop_miss),
                     (idx == 255) || ($urandom_range(0, 4) == 0));
  endfunction

  task automatic send_word(input tree_word_t c);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    request_ch.op <= c.op;
    request_ch.node_index <= c.node_index;
    request_ch.node_feature <= c.node_feature;
    request_ch.node_threshold <= c.node_threshold;
    request_ch.node_yes <= c.node_yes;
    request_ch.node_no <= c.node_no;
    request_ch.node_missing <= c.node_missing;
    request_ch.node_is_leaf <= c.node_is_leaf;
    request_ch.feature_index <= c.feature_index;
    request_ch.feature_value <= c.feature_value;
    request_ch.feature_missing <= c.feature_missing;
    request_ch.valid <= 1'b1;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    case (c.op)
      dtl_pkg::OP_NODE: begin
        tree_feat[c.node_index] = c.node_feature;
        tree_thr[c.node_index] = c.node_threshold;
        tree_yes[c.node_index] = c.node_yes;
        tree_no[c.node_index] = c.node_no;
        tree_miss[c.node_index] = c.node_missing;
        tree_leaf[c.node_index] = c.node_is_leaf;
        loads_sent++;
      end
      dtl_pkg::OP_FEAT: begin
        obs_value[c.feature_index] = c.feature_value;
        obs_missing[c.feature_index] = c.feature_missing;
        loads_sent++;
      end
      dtl_pkg::OP_WALK: begin
        expected_leaves.push_back(predict_leaf());
        walks_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic settle_block();
    request_ch.valid <= 1'b0;
    while (expected_leaves.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_step_limit(input logic [dtl_pkg::STEPS_W-1:0] steps);
    settle_block();
    cfg_ch.max_walk_steps <= steps;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    walk_limit = steps;
  endtask

  task automatic test_directed_routing();
    send_word(node_word(8'd1, 6'd0, 32'sd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_word(node_word(8'd2, 6'd0, 32'sd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_word(node_word(8'd255, 6'd63, 32'sh7fff_ffff, 8'd255, 8'd255, 8'd255, 1'b1));
    send_word(node_word(8'd0, 6'd63, 32'sh8000_0000, 8'd1, 8'd255, 8'd2, 1'b0));
    send_word(feat_word(6'd63, 32'sh8000_0000, 1'b0));
    send_word(walk_word());
    send_word(feat_word(6'd63, 32'sh7fff_ffff, 1'b1));
    send_word(walk_word());
    send_word(node_word(8'd0, 6'd63, 32'sh7fff_ffff, 8'd1, 8'd255, 8'd2, 1'b0));
    send_word(feat_word(6'd63, 32'sh7fff_ffff, 1'b0));
    send_word(walk_word());
    send_word(feat_word(6'd63, 32'sh8000_0000, 1'b0));
    send_word(walk_word());
    send_word('{op: OP_SPARE, node_index: 8'd0, node_feature: 6'd0, node_threshold: 32'sd0,
                node_yes: 8'd0, node_no: 8'd0, node_missing: 8'd0, node_is_leaf: 1'b1,
                feature_index: 6'd63, feature_value: 32'sd0, feature_missing: 1'b1});
    send_word(walk_word());
  endtask

  task automatic test_step_limit_edges();
    write_step_limit(9'd0);
    send_word(walk_word());
    write_step_limit(9'd1);
    send_word(walk_word());
    write_step_limit(9'd2);
    send_word(walk_word());
    write_step_limit(9'd511);
    send_word(node_word(8'd0, 6'd63, 32'sd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(walk_word());
    send_word(node_word(8'd0, 6'd63, 32'sd0, 8'd1, 8'd2, 8'd255, 1'b1));
    send_word(walk_word());
  endtask

  task automatic test_full_load();
    for (int i = 0; i < 256; i++) send_word(grown_node(i, 1'b0));
    for (int f = 0; f < 64; f++)
      send_word(feat_word(dtl_pkg::FEAT_W'(f), pick_value(), $urandom_range(0, 6) == 0));
  endtask

  task automatic test_random_traffic(input int count, input int noise_pct);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_word(grown_node($urandom_range(0, 255), $urandom_range(0, 99) < noise_pct));
      else if (pick < 70)
        send_word(feat_word(dtl_pkg::FEAT_W'($urandom), pick_value(),
                            $urandom_range(0, 6) == 0));
      else if (pick < 97)
        send_word(walk_word());
      else
        send_word(random_word());
    end
  endtask

  task automatic test_backpressure();
    settle_block();
    hold_cycles = 400;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 0)
        send_word(walk_word());
      else
        send_word(feat_word(dtl_pkg::FEAT_W'($urandom), pick_value(),
                            $urandom_range(0, 6) == 0));
    end
  endtask

  task automatic test_unpaced_traffic();
    settle_block();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    write_step_limit(9'd256);
    test_random_traffic(250, 4);
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        result_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    leaf_result_t exp_leaf;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_leaves.size() == 0) begin
        $display("%0t: unexpected result word leaf_id=%0d walk_overrun=%0b", $time,
                 result_ch.leaf_id, result_ch.walk_overrun);
        error_count++;
      end else begin
        exp_leaf = expected_leaves.pop_front();
        results_checked++;
        if (result_ch.walk_overrun === 1'b1) overruns_seen++;
        if (result_ch.leaf_id !== exp_leaf.leaf_id) begin
          $display("%0t: leaf_id mismatch expected=%0d actual=%0d", $time,
                   exp_leaf.leaf_id, result_ch.leaf_id);
          error_count++;
        end
        if (result_ch.walk_overrun !== exp_leaf.walk_overrun) begin
          $display("%0t: walk_overrun mismatch expected=%0b actual=%0b", $time,
                   exp_leaf.walk_overrun, result_ch.walk_overrun);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_count);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    request_ch.valid <= 1'b0;
    request_ch.op <= dtl_pkg::OP_NODE;
    request_ch.node_index <= '0;
    request_ch.node_feature <= '0;
    request_ch.node_threshold <= '0;
    request_ch.node_yes <= '0;
    request_ch.node_no <= '0;
    request_ch.node_missing <= '0;
    request_ch.node_is_leaf <= 1'b0;
    request_ch.feature_index <= '0;
    request_ch.feature_value <= '0;
    request_ch.feature_missing <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.max_walk_steps <= dtl_pkg::STEPS_RESET;
    walk_limit = dtl_pkg::STEPS_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_routing();
    test_step_limit_edges();
    write_step_limit(9'd256);
    test_full_load();
    test_random_traffic(250, 4);
    write_step_limit(9'd3);
    test_random_traffic(200, 4);
    write_step_limit(9'd511);
    test_random_traffic(150, 10);
    write_step_limit(9'd9);
    test_random_traffic(150, 4);
    test_backpressure();
    test_unpaced_traffic();
    settle_block();
    repeat (20) @(posedge clk);
    $display("Sent %0d classify and %0d table write words; checked %0d results, %0d overrun.",
             walks_sent, loads_sent, results_checked, overruns_seen);
    $display("Step limits 0, 1, 2, 3, 9, 256 and 511 were used, with stalls and a long hold.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
